[rtl/sbusrx_pkg.sv]
`default_nettype none
package sbusrx_pkg;

  // Frame layout
  localparam int FRAME_BYTES = 25;
  localparam int NUM_CH      = 16;
  localparam int CH_W        = 11;
  localparam int POS_W       = 5;

  localparam logic [7:0] SYNC_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE  = 8'h00;

  localparam logic [POS_W-1:0] LAST_DATA_POS = POS_W'(22);
  localparam logic [POS_W-1:0] FLAGS_POS     = POS_W'(23);
  localparam logic [POS_W-1:0] END_POS       = POS_W'(FRAME_BYTES - 1);

  // Flag byte bits
  localparam int FLAG_LOST_BIT = 2;
  localparam int FLAG_FS_BIT   = 3;

  // Signal status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_LOST     = 2'd1;
  localparam logic [1:0] STATUS_FAILSAFE = 2'd2;

  // Stick end points
  localparam logic [CH_W-1:0] FWD_HI = 11'd1798;
  localparam logic [CH_W-1:0] FWD_LO = 11'd173;
  localparam logic [CH_W-1:0] TRN_HI = 11'd1809;
  localparam logic [CH_W-1:0] TRN_LO = 11'd181;

  // Register map (index = byte address / 4)
  localparam logic [2:0] REG_MODE_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_FORWARD_CENTER = 3'd1;
  localparam logic [2:0] REG_TURN_CENTER    = 3'd2;
  localparam logic [2:0] REG_DEAD_ZONE      = 3'd3;
  localparam logic [2:0] REG_SPEED_LIMIT    = 3'd4;

  localparam int ZONE_W  = 9;
  localparam int LIMIT_W = 10;

  // Speed mapping request and answer
  typedef struct packed {
    logic            start;
    logic [CH_W-1:0] value;
    logic [CH_W-1:0] center;
    logic [CH_W-1:0] end_hi;
    logic [CH_W-1:0] end_lo;
  } spd_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [CH_W-1:0] speed;
  } spd_rsp_t;

endpackage
`default_nettype wire

[rtl/sbusrx_speed.sv]
`default_nettype none
// Stick-to-speed mapping: one multiply, then a restoring divide one bit a cycle.
module sbusrx_speed (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire sbusrx_pkg::spd_req_t                req,
  input  wire logic [sbusrx_pkg::ZONE_W-1:0]       dead_zone,
  input  wire logic [sbusrx_pkg::LIMIT_W-1:0]      speed_limit,
  output sbusrx_pkg::spd_rsp_t                     rsp
);

  localparam int CH_W   = sbusrx_pkg::CH_W;
  localparam int PROD_W = sbusrx_pkg::CH_W + sbusrx_pkg::LIMIT_W;
  localparam int CNT_W  = $clog2(PROD_W);

  localparam logic [1:0] SP_IDLE = 2'd0;
  localparam logic [1:0] SP_MUL  = 2'd1;
  localparam logic [1:0] SP_DIV  = 2'd2;
  localparam logic [1:0] SP_FIN  = 2'd3;

  logic [1:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic [CH_W-1:0]   mag;
  logic [CH_W-1:0]   divisor;
  logic              neg;
  logic              zero;
  logic [PROD_W-1:0] dvd;
  logic [CH_W:0]     rem;

  logic signed [CH_W:0] diff;
  logic signed [CH_W:0] span_hi;
  logic signed [CH_W:0] span_lo;
  logic signed [CH_W:0] span;
  logic [CH_W-1:0]      mag_in;
  logic [CH_W:0]        trial;
  logic                 fits;
  logic signed [CH_W-1:0] sat;

  // Operand set-up: offset from centre, its magnitude and the divisor
  always_comb begin
    diff    = $signed({1'b0, req.value}) - $signed({1'b0, req.center});
    span_hi = $signed({1'b0, req.end_hi}) - $signed({1'b0, req.center});
    span_lo = $signed({1'b0, req.center}) - $signed({1'b0, req.end_lo});
    span    = (diff > 0) ? span_hi : span_lo;
    mag_in  = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
  end

  // One restoring divide step
  always_comb begin
    trial = {rem[CH_W-1:0], dvd[PROD_W-1]};
    fits  = trial >= {1'b0, divisor};
  end

  // Clamp the truncated quotient into the output range; zero inside the dead band
  always_comb begin
    if (zero) begin
      sat = '0;
    end else if (neg) begin
      sat = (dvd > PROD_W'(1024)) ? -11'sd1024 : $signed(CH_W'(-dvd[CH_W-1:0]));
    end else begin
      sat = (dvd > PROD_W'(1023)) ? 11'sd1023 : $signed(dvd[CH_W-1:0]);
    end
    rsp.done  = state == SP_FIN;
    rsp.speed = sat;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SP_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        SP_IDLE: if (req.start) state <= SP_MUL;
        SP_MUL: begin
          cnt   <= '0;
          state <= zero ? SP_FIN : SP_DIV;
        end
        SP_DIV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(PROD_W - 1)) state <= SP_FIN;
        end
        SP_FIN:  state <= SP_IDLE;
        default: state <= SP_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      SP_IDLE: begin
        mag     <= mag_in;
        neg     <= diff[CH_W];
        zero    <= {1'b0, mag_in} < {3'b0, dead_zone};
        divisor <= (span < 1) ? CH_W'(1) : span[CH_W-1:0];
      end
      SP_MUL: begin
        dvd <= PROD_W'(mag) * PROD_W'(speed_limit);
        rem <= '0;
      end
      SP_DIV: begin
        rem <= fits ? (trial - {1'b0, divisor}) : trial;
        dvd <= {dvd[PROD_W-2:0], fits};
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/sbus_frame_receiver_decoder_unit.sv]
`default_nettype none
// Channel   | Dir | Handshake                  | Content
// s_*       | in  | s_tvalid/s_tready          | received byte
// m_*       | out | m_tvalid/m_tready, m_tlast | one decoded channel per word
// APB       | in  | psel/penable/pready        | five 32-bit registers at 0x00..0x10
//
// Receive: one byte word per cycle while s_tready is high; channels are unpacked on
// the fly as bytes land. Frame end: two speed mappings in the shared multiply/divide
// unit (the divide is skipped when the stick sits inside the dead band), then 16 result
// words, one per cycle while m_tready is high; s_tready is low throughout.
// A bad end byte drops the frame with no words; without valid drive the mappings are skipped.
// Reset clears framing state, drive mode and registers to their defaults.
module sbus_frame_receiver_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [3:0] channel_index, [14:4] channel_value, [16:15] signal_status,
  // [17] drive_mode, [18] drive_valid, [29:19] forward_speed, [40:30] turn_rate
  output logic [47:0]      m_tdata,
  output logic             m_tlast,   // last_of_frame
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CH_W  = sbusrx_pkg::CH_W;
  localparam int POS_W = sbusrx_pkg::POS_W;
  localparam int IDX_W = $clog2(sbusrx_pkg::NUM_CH);
  localparam int ACC_W = CH_W + 7;

  localparam logic [1:0] ST_RX   = 2'd0;
  localparam logic [1:0] ST_FWD  = 2'd1;
  localparam logic [1:0] ST_TURN = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // Configuration registers
  logic [CH_W-1:0]                  mode_threshold;
  logic [CH_W-1:0]                  forward_center;
  logic [CH_W-1:0]                  turn_center;
  logic [sbusrx_pkg::ZONE_W-1:0]    dead_zone;
  logic [sbusrx_pkg::LIMIT_W-1:0]   speed_limit;

  logic [1:0]       state;
  logic             in_frame;
  logic [POS_W-1:0] byte_pos;
  logic             control_mode;
  logic             go;
  logic [IDX_W-1:0] out_idx;

  logic [ACC_W-1:0] acc;
  logic [4:0]       nb;
  logic [IDX_W-1:0] ch_cnt;
  logic [CH_W-1:0]  ch [sbusrx_pkg::NUM_CH];
  logic [7:0]       flags;
  logic [1:0]       status;
  logic             drive_valid;
  logic signed [CH_W-1:0] fwd;
  logic signed [CH_W-1:0] turn;

  logic             cfg_wr;
  logic             rx_take;
  logic [POS_W-1:0] pos_next;
  logic [ACC_W-1:0] acc_wide;
  logic [4:0]       nb_sum;
  logic             dec_en;
  logic             end_ok;
  logic [1:0]       status_new;
  logic             mode_new;
  logic             valid_new;

  sbusrx_pkg::spd_req_t spd_req;
  sbusrx_pkg::spd_rsp_t spd_rsp;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[4:2])
      sbusrx_pkg::REG_MODE_THRESHOLD: prdata = 32'(mode_threshold);
      sbusrx_pkg::REG_FORWARD_CENTER: prdata = 32'(forward_center);
      sbusrx_pkg::REG_TURN_CENTER:    prdata = 32'(turn_center);
      sbusrx_pkg::REG_DEAD_ZONE:      prdata = 32'(dead_zone);
      sbusrx_pkg::REG_SPEED_LIMIT:    prdata = 32'(speed_limit);
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_threshold <= 11'd1000;
      forward_center <= 11'd997;
      turn_center    <= 11'd992;
      dead_zone      <= 9'd50;
      speed_limit    <= 10'd500;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        sbusrx_pkg::REG_MODE_THRESHOLD: mode_threshold <= pwdata[CH_W-1:0];
        sbusrx_pkg::REG_FORWARD_CENTER: forward_center <= pwdata[CH_W-1:0];
        sbusrx_pkg::REG_TURN_CENTER:    turn_center    <= pwdata[CH_W-1:0];
        sbusrx_pkg::REG_DEAD_ZONE:      dead_zone      <= pwdata[sbusrx_pkg::ZONE_W-1:0];
        sbusrx_pkg::REG_SPEED_LIMIT:    speed_limit    <= pwdata[sbusrx_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Byte intake, bit unpacking and frame-end decisions
  always_comb begin
    rx_take  = s_tvalid & s_tready;
    pos_next = byte_pos + POS_W'(1);
    acc_wide = acc | (ACC_W'(s_tdata) << nb);
    nb_sum   = nb + 5'd8;
    dec_en   = rx_take & in_frame & (pos_next <= sbusrx_pkg::LAST_DATA_POS);
    end_ok   = rx_take & in_frame & (pos_next == sbusrx_pkg::END_POS)
               & (s_tdata == sbusrx_pkg::END_BYTE);
    if (flags[sbusrx_pkg::FLAG_LOST_BIT]) begin
      status_new = sbusrx_pkg::STATUS_LOST;
    end else if (flags[sbusrx_pkg::FLAG_FS_BIT]) begin
      status_new = sbusrx_pkg::STATUS_FAILSAFE;
    end else begin
      status_new = sbusrx_pkg::STATUS_OK;
    end
    mode_new  = (status_new == sbusrx_pkg::STATUS_OK) ? (ch[4] >= mode_threshold)
                                                      : control_mode;
    valid_new = (status_new == sbusrx_pkg::STATUS_OK) & mode_new;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RX;
      in_frame     <= 1'b0;
      byte_pos     <= '0;
      control_mode <= 1'b0;
      go           <= 1'b0;
      out_idx      <= '0;
    end else begin
      unique case (state)
        ST_RX: begin
          go <= end_ok & valid_new;
          if (rx_take) begin
            if (!in_frame) begin
              if (s_tdata == sbusrx_pkg::SYNC_BYTE) begin
                in_frame <= 1'b1;
                byte_pos <= '0;
              end
            end else begin
              byte_pos <= pos_next;
              if (pos_next == sbusrx_pkg::END_POS) in_frame <= 1'b0;
            end
          end
          if (end_ok) begin
            control_mode <= mode_new;
            out_idx      <= '0;
            if (valid_new) begin
              state <= ST_FWD;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_FWD: begin
          go <= spd_rsp.done;
          if (spd_rsp.done) begin
            state <= ST_TURN;
          end
        end
        ST_TURN: begin
          go <= 1'b0;
          if (spd_rsp.done) state <= ST_OUT;
        end
        ST_OUT: begin
          go <= 1'b0;
          if (m_tready) begin
            out_idx <= out_idx + IDX_W'(1);
            if (out_idx == IDX_W'(sbusrx_pkg::NUM_CH - 1)) state <= ST_RX;
          end
        end
        default: begin
          go    <= 1'b0;
          state <= ST_RX;
        end
      endcase
    end
  end

  // Payload: unpack channels, hold flags and speeds
  always_ff @(posedge clk) begin
    if (rx_take && !in_frame && s_tdata == sbusrx_pkg::SYNC_BYTE) begin
      acc    <= '0;
      nb     <= '0;
      ch_cnt <= '0;
    end
    if (dec_en) begin
      if (nb_sum >= 5'(CH_W)) begin
        ch[ch_cnt] <= acc_wide[CH_W-1:0];
        ch_cnt     <= ch_cnt + IDX_W'(1);
        acc        <= acc_wide >> CH_W;
        nb         <= nb_sum - 5'(CH_W);
      end else begin
        acc <= acc_wide;
        nb  <= nb_sum;
      end
    end
    if (rx_take && in_frame && pos_next == sbusrx_pkg::FLAGS_POS) flags <= s_tdata;
    if (end_ok) begin
      status      <= status_new;
      drive_valid <= valid_new;
      fwd         <= '0;
      turn        <= '0;
    end
    if (state == ST_FWD && spd_rsp.done) fwd <= spd_rsp.speed;
    if (state == ST_TURN && spd_rsp.done) turn <= spd_rsp.speed;
  end

  // Shared speed mapper
  always_comb begin
    spd_req.start = go;
    if (state == ST_TURN) begin
      spd_req.value  = ch[3];
      spd_req.center = turn_center;
      spd_req.end_hi = sbusrx_pkg::TRN_HI;
      spd_req.end_lo = sbusrx_pkg::TRN_LO;
    end else begin
      spd_req.value  = ch[1];
      spd_req.center = forward_center;
      spd_req.end_hi = sbusrx_pkg::FWD_HI;
      spd_req.end_lo = sbusrx_pkg::FWD_LO;
    end
  end

  sbusrx_speed u_speed (
    .clk         (clk),
    .rst         (rst),
    .req         (spd_req),
    .dead_zone   (dead_zone),
    .speed_limit (speed_limit),
    .rsp         (spd_rsp)
  );

  // Stream ports
  assign s_tready = state == ST_RX;
  assign m_tvalid = state == ST_OUT;
  assign m_tlast  = out_idx == IDX_W'(sbusrx_pkg::NUM_CH - 1);
  assign m_tdata  = {7'b0, turn, fwd, drive_valid, control_mode, status,
                     ch[out_idx], out_idx};

endmodule
`default_nettype wire
